// ===== design/c3rb_pkg.sv =====
package c3rb_pkg;

    // Line store geometry and position counter widths.
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int MAX_WIDTH  = 1 << COL_W;
    localparam int MAX_HEIGHT = 1 << ROW_W;
    localparam int DIM_W      = 11;
    localparam int PIX_W      = 8;
    localparam int VALUE_W    = 20;
    localparam int PROD_W     = 17;

    // Register file layout.
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 64;
    localparam int UPPER_W    = 48;
    localparam int LOWER_W    = 24;

    localparam logic [1:0] REG_COEFF_UPPER  = 2'd0;
    localparam logic [1:0] REG_COEFF_LOWER  = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

    typedef logic [PIX_W-1:0]   pixel_t;
    typedef logic [COL_W-1:0]   col_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [DIM_W-1:0]   dim_t;
    typedef logic signed [PIX_W-1:0] coeff_t;
    typedef logic [1:0]         win_idx_t;

    // Clamp a programmed dimension into 1..max_value.
    function automatic dim_t eff_dim(input dim_t v, input dim_t max_value);
        dim_t result;
        if (v == '0) begin
            result = dim_t'(1);
        end
        else if (v > max_value) begin
            result = max_value;
        end
        else begin
            result = v;
        end
        return result;
    endfunction

endpackage

// ===== design/conv3x3_replicate_border.sv =====
// 3x3 convolution over a raster pixel stream, with the border pixels repeated
// on all four sides.
// Input channel: pixel with in_valid/in_ready, one pixel per request in raster
// order. Output channel: value, row, column and run_last with
// out_valid/out_ready; run_last marks the last result released by a pixel.
// Configuration goes through the APB port (coefficients, width, height) and must be
// written only while the stream is idle; the block does not enforce this. pready is
// always high. Results trail the input by one row and one pixel; a pixel passes the
// pixel stage and the result stage before its first result reaches the output
// register. Throughput is one pixel per cycle while each pixel releases at most one
// result and the receiver does not stall. A pixel that releases n results holds the
// shared multiply-add unit until all n are issued (up to four at row ends of the last
// row), and the input stalls behind it. Two line stores of 1024 bytes each are read
// at accept and written when that pixel moves on, with a bypass for back-to-back use
// of one column. Reset clears the window, the position counters and all pipeline
// valid flags; no clearing pass runs, so in_ready is high as soon as reset ends. When
// the receiver stalls, the result holds in the output register, one more pixel waits
// in each of the two stages, and then in_ready drops.
module conv3x3_replicate_border (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [c3rb_pkg::ADDR_W-1:0]       paddr,
    input  logic [c3rb_pkg::DATA_W-1:0]       pwdata,
    output logic [c3rb_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [c3rb_pkg::PIX_W-1:0]        pixel,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [c3rb_pkg::VALUE_W-1:0] value,
    output logic [c3rb_pkg::ROW_W-1:0]        row,
    output logic [c3rb_pkg::COL_W-1:0]        column,
    output logic                              run_last
);

    // Configuration registers.
    logic [c3rb_pkg::UPPER_W-1:0] coeff_upper_reg;
    logic [c3rb_pkg::LOWER_W-1:0] coeff_lower_reg;
    c3rb_pkg::dim_t               image_width_reg;
    c3rb_pkg::dim_t               image_height_reg;

    // Position of the next pixel.
    c3rb_pkg::col_t col_reg;
    c3rb_pkg::row_t row_reg;

    // Line stores and their registered read data.
    c3rb_pkg::pixel_t older_mem [c3rb_pkg::MAX_WIDTH];
    c3rb_pkg::pixel_t newer_mem [c3rb_pkg::MAX_WIDTH];
    c3rb_pkg::pixel_t rd_older_reg;
    c3rb_pkg::pixel_t rd_newer_reg;
    logic             fwd_reg;
    c3rb_pkg::pixel_t fwd_older_reg;
    c3rb_pkg::pixel_t fwd_newer_reg;

    // Pixel stage.
    logic             p_valid_reg;
    c3rb_pkg::pixel_t p_px_reg;
    c3rb_pkg::col_t   p_col_reg;
    c3rb_pkg::row_t   p_row_reg;
    logic             p_row_end_reg;
    logic             p_last_row_reg;

    // Result stage: window and the pending result mask.
    c3rb_pkg::pixel_t win_reg [3][3];
    logic [3:0]       e_mask_reg;
    c3rb_pkg::col_t   e_col_reg;
    c3rb_pkg::row_t   e_row_reg;

    // Output register.
    logic                                  out_valid_reg;
    logic signed [c3rb_pkg::VALUE_W-1:0]   value_reg;
    c3rb_pkg::row_t                        row_out_reg;
    c3rb_pkg::col_t                        column_reg;
    logic                                  run_last_reg;

    logic             cfg_write;
    logic             in_accept;
    logic             p_move;
    logic             e_issue;
    logic             e_finishing;
    logic [3:0]       mask_after;
    c3rb_pkg::dim_t   w_eff;
    c3rb_pkg::dim_t   h_eff;
    logic             row_end;
    logic             last_row;
    c3rb_pkg::pixel_t older_eff;
    c3rb_pkg::pixel_t newer_eff;
    logic [3:0]       p_mask;
    logic             pick_ab;
    logic             pick_ac;
    c3rb_pkg::win_idx_t rs [3];
    c3rb_pkg::win_idx_t cs [3];
    c3rb_pkg::coeff_t   kern [9];
    logic signed [c3rb_pkg::PROD_W-1:0]  prod [9];
    logic signed [c3rb_pkg::VALUE_W-1:0] sum;
    c3rb_pkg::row_t     issue_row;
    c3rb_pkg::col_t     issue_col;

    // APB access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_upper_reg  <= '0;
            coeff_lower_reg  <= '0;
            image_width_reg  <= c3rb_pkg::dim_t'(c3rb_pkg::MAX_WIDTH);
            image_height_reg <= c3rb_pkg::dim_t'(c3rb_pkg::MAX_HEIGHT);
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:3])
                c3rb_pkg::REG_COEFF_UPPER:  coeff_upper_reg  <= pwdata[c3rb_pkg::UPPER_W-1:0];
                c3rb_pkg::REG_COEFF_LOWER:  coeff_lower_reg  <= pwdata[c3rb_pkg::LOWER_W-1:0];
                c3rb_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[c3rb_pkg::DIM_W-1:0];
                c3rb_pkg::REG_IMAGE_HEIGHT: image_height_reg <= pwdata[c3rb_pkg::DIM_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            c3rb_pkg::REG_COEFF_UPPER:  prdata = c3rb_pkg::DATA_W'(coeff_upper_reg);
            c3rb_pkg::REG_COEFF_LOWER:  prdata = c3rb_pkg::DATA_W'(coeff_lower_reg);
            c3rb_pkg::REG_IMAGE_WIDTH:  prdata = c3rb_pkg::DATA_W'(image_width_reg);
            c3rb_pkg::REG_IMAGE_HEIGHT: prdata = c3rb_pkg::DATA_W'(image_height_reg);
        endcase
    end

    // Handshake and stage movement.
    assign mask_after  = e_mask_reg & (e_mask_reg - 4'd1);
    assign e_issue     = (e_mask_reg != '0) && (!out_valid_reg || out_ready);
    assign e_finishing = e_issue && (mask_after == '0);
    assign p_move      = p_valid_reg && ((e_mask_reg == '0) || e_finishing);
    assign in_ready    = !p_valid_reg || p_move;
    assign in_accept   = in_valid && in_ready;

    // Row end and last row for the pixel being accepted.
    assign w_eff    = c3rb_pkg::eff_dim(image_width_reg, c3rb_pkg::dim_t'(c3rb_pkg::MAX_WIDTH));
    assign h_eff    = c3rb_pkg::eff_dim(image_height_reg, c3rb_pkg::dim_t'(c3rb_pkg::MAX_HEIGHT));
    assign row_end  = ({1'b0, col_reg} + c3rb_pkg::dim_t'(1)) >= w_eff;
    assign last_row = ({1'b0, row_reg} + c3rb_pkg::dim_t'(1)) >= h_eff;

    // Position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_accept)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + c3rb_pkg::row_t'(1);
            end
            else
            begin
                col_reg <= col_reg + c3rb_pkg::col_t'(1);
            end
        end
    end

    // Line stores: read at accept, written when the pixel leaves its stage.
    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            older_mem[p_col_reg] <= newer_eff;
            newer_mem[p_col_reg] <= p_px_reg;
        end
        if (in_accept)
        begin
            rd_older_reg <= older_mem[col_reg];
            rd_newer_reg <= newer_mem[col_reg];
        end
    end

    // Bypass for a read of the column written at the same edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            fwd_reg <= p_move && (p_col_reg == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fwd_older_reg <= newer_eff;
            fwd_newer_reg <= p_px_reg;
        end
    end

    assign older_eff = fwd_reg ? fwd_older_reg : rd_older_reg;
    assign newer_eff = fwd_reg ? fwd_newer_reg : rd_newer_reg;

    // Pixel stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            p_valid_reg <= 1'b1;
        end
        else if (p_move)
        begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            p_px_reg       <= pixel;
            p_col_reg      <= col_reg;
            p_row_reg      <= row_reg;
            p_row_end_reg  <= row_end;
            p_last_row_reg <= last_row;
        end
    end

    // Results this pixel releases, in output order.
    assign p_mask[0] = (p_row_reg != '0) && (p_col_reg != '0);
    assign p_mask[1] = (p_row_reg != '0) && p_row_end_reg;
    assign p_mask[2] = p_last_row_reg && (p_col_reg != '0);
    assign p_mask[3] = p_last_row_reg && p_row_end_reg;

    // Window shift and result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
            e_mask_reg <= '0;
        end
        else if (p_move)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= older_eff;
            win_reg[1][2] <= newer_eff;
            win_reg[2][2] <= p_px_reg;
            e_mask_reg    <= p_mask;
        end
        else if (e_issue)
        begin
            e_mask_reg <= mask_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p_move)
        begin
            e_col_reg <= p_col_reg;
            e_row_reg <= p_row_reg;
        end
    end

    // Pick the lowest pending result and its window rows and columns.
    always_comb
    begin
        priority if (e_mask_reg[0])
        begin
            pick_ab = 1'b1;
            pick_ac = 1'b1;
        end
        else if (e_mask_reg[1])
        begin
            pick_ab = 1'b1;
            pick_ac = 1'b0;
        end
        else if (e_mask_reg[2])
        begin
            pick_ab = 1'b0;
            pick_ac = 1'b1;
        end
        else
        begin
            pick_ab = 1'b0;
            pick_ac = 1'b0;
        end

        // Rows above or below the output row repeat it at the top or bottom edge.
        if (pick_ab)
        begin
            rs[0] = (e_row_reg == c3rb_pkg::row_t'(1)) ? 2'd1 : 2'd0;
            rs[1] = 2'd1;
        end
        else
        begin
            rs[0] = (e_row_reg == '0) ? 2'd2 : 2'd1;
            rs[1] = 2'd2;
        end
        rs[2] = 2'd2;

        // Left and right edge columns repeat the nearest pixel.
        if (pick_ac)
        begin
            cs[0] = (e_col_reg == c3rb_pkg::col_t'(1)) ? 2'd1 : 2'd0;
            cs[1] = 2'd1;
        end
        else
        begin
            cs[0] = (e_col_reg == '0) ? 2'd2 : 2'd1;
            cs[1] = 2'd2;
        end
        cs[2] = 2'd2;

        issue_row = pick_ab ? e_row_reg - c3rb_pkg::row_t'(1) : e_row_reg;
        issue_col = pick_ac ? e_col_reg - c3rb_pkg::col_t'(1) : e_col_reg;
    end

    // Kernel coefficients unpacked from the two registers.
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            kern[k] = coeff_upper_reg[8*k +: 8];
        end
        for (int k = 0; k < 3; k++)
        begin
            kern[6+k] = coeff_lower_reg[8*k +: 8];
        end
    end

    // Shared multiply-add over the selected 3x3 neighborhood.
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod[i*3+j] = kern[i*3+j] * $signed({1'b0, win_reg[rs[i]][cs[j]]});
            end
        end
        for (int k = 0; k < 9; k++)
        begin
            sum = sum + {{(c3rb_pkg::VALUE_W - c3rb_pkg::PROD_W){prod[k][c3rb_pkg::PROD_W-1]}},
                         prod[k]};
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (e_issue)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_issue)
        begin
            value_reg    <= sum;
            row_out_reg  <= issue_row;
            column_reg   <= issue_col;
            run_last_reg <= (mask_after == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign row       = row_out_reg;
    assign column    = column_reg;
    assign run_last  = run_last_reg;

    // While a result that is not the last of its pixel is shown, out_valid stays high.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |=> out_valid)
        else $error("result run ended without run_last");

    // A waiting pixel keeps its stage contents.
    a_pixel_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && !p_move) |=> (p_valid_reg && $stable(p_px_reg) && $stable(p_col_reg)))
        else $error("pixel stage lost a waiting request");

    // After a non-final issue, results remain pending.
    a_mask_remains: assert property (@(posedge clk) disable iff (!rst_n)
        (e_issue && !e_finishing && !p_move) |=> (e_mask_reg != '0))
        else $error("pending results dropped");

endmodule
